FILE: hdl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared constants for the sorted key table: widths, default capacity,
// request codes and status codes.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int KEY_W        = 32;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 2;
  localparam int COUNT_OUT_W  = 5;
  localparam int DEF_CAPACITY = 16;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_CHANGE = 2'd2;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

endpackage

FILE: hdl/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table
// Bounded table of signed keys kept in ascending order, duplicates allowed.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the request completes. Exactly one result follows each request: done
// pulses for one cycle with status, found and entry_count, and the receiver
// cannot stall it. The keys live in one RAM with a single read and a single
// write port, and the sequencer walks it one entry per cycle: a scan for the
// first key not smaller than the request key, then a one-place shift for
// insert or remove. A search only scans; an insert with room, or a remove
// that finds its key, scans and then shifts, and a change does a remove
// followed by an insert of the new key. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [OP_W-1:0]            op,
  input  logic signed [KEY_W-1:0]    key,
  input  logic signed [KEY_W-1:0]    new_key,
  output logic                       busy,
  output logic                       done,
  output logic [STATUS_W-1:0]        status,
  output logic                       found,
  output logic [COUNT_OUT_W-1:0]     entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_REMV   = 3'd3;
  localparam logic [2:0] S_INS    = 3'd4;

  logic [2:0]              state;
  logic [CW-1:0]           count;
  logic                    phase;
  logic [OP_W-1:0]         op_r;
  logic signed [KEY_W-1:0] cur_key;
  logic signed [KEY_W-1:0] new_key_r;
  logic [CW-1:0]           scan_idx;
  logic [CW-1:0]           cmp_idx;
  logic                    cmp_vld;
  logic [CW-1:0]           pos;
  logic                    hit_eq;
  logic [CW-1:0]           sh_idx;
  logic                    wr_vld;
  logic [AW-1:0]           wr_addr;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [KEY_W-1:0]        ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [KEY_W-1:0]        rd_data;

  logic [CW-1:0]           sh_dec;
  logic                    hit;

  skt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign busy        = (state != S_IDLE);
  assign entry_count = COUNT_OUT_W'(count);
  assign sh_dec      = sh_idx - 1'b1;
  assign hit         = cmp_vld && !($signed(rd_data) < cur_key);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr;
    ram_wdata = rd_data;
    ram_raddr = scan_idx[AW-1:0];
    unique case (state)
      S_REMV: begin
        ram_raddr = sh_idx[AW-1:0];
        ram_we    = wr_vld;
      end
      S_INS: begin
        ram_raddr = sh_dec[AW-1:0];
        ram_we    = wr_vld || (sh_idx == pos);
        if (!wr_vld) begin
          ram_waddr = pos[AW-1:0];
          ram_wdata = cur_key;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      done    <= 1'b0;
      cmp_vld <= 1'b0;
      wr_vld  <= 1'b0;
      phase   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_r      <= op;
            cur_key   <= key;
            new_key_r <= new_key;
            phase     <= 1'b0;
            scan_idx  <= '0;
            cmp_vld   <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            pos     <= cmp_idx;
            hit_eq  <= ($signed(rd_data) == cur_key);
            cmp_vld <= 1'b0;
            state   <= S_DECIDE;
          end else if (scan_idx == count) begin
            pos     <= count;
            hit_eq  <= 1'b0;
            cmp_vld <= 1'b0;
            state   <= S_DECIDE;
          end else begin
            cmp_vld  <= 1'b1;
            cmp_idx  <= scan_idx;
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_DECIDE: begin
          wr_vld <= 1'b0;
          if (phase) begin
            sh_idx <= count;
            state  <= S_INS;
          end else begin
            found <= hit_eq;
            unique case (op_r)
              OP_INSERT: begin
                if (count == CW'(CAPACITY)) begin
                  status <= ST_FULL;
                  done   <= 1'b1;
                  state  <= S_IDLE;
                end else begin
                  sh_idx <= count;
                  state  <= S_INS;
                end
              end
              OP_REMOVE, OP_CHANGE: begin
                if (hit_eq) begin
                  sh_idx <= pos + 1'b1;
                  state  <= S_REMV;
                end else begin
                  status <= ST_NOT_FOUND;
                  done   <= 1'b1;
                  state  <= S_IDLE;
                end
              end
              default: begin
                status <= hit_eq ? ST_DONE : ST_NOT_FOUND;
                done   <= 1'b1;
                state  <= S_IDLE;
              end
            endcase
          end
        end
        S_REMV: begin
          if (sh_idx < count) begin
            wr_vld  <= 1'b1;
            wr_addr <= sh_dec[AW-1:0];
            sh_idx  <= sh_idx + 1'b1;
          end else if (wr_vld) begin
            wr_vld <= 1'b0;
          end else begin
            count <= count - 1'b1;
            if (op_r == OP_CHANGE) begin
              phase    <= 1'b1;
              cur_key  <= new_key_r;
              scan_idx <= '0;
              cmp_vld  <= 1'b0;
              state    <= S_SCAN;
            end else begin
              status <= ST_DONE;
              done   <= 1'b1;
              state  <= S_IDLE;
            end
          end
        end
        S_INS: begin
          if (sh_idx != pos) begin
            wr_vld  <= 1'b1;
            wr_addr <= sh_idx[AW-1:0];
            sh_idx  <= sh_dec;
          end else if (wr_vld) begin
            wr_vld <= 1'b0;
          end else begin
            count  <= count + 1'b1;
            status <= ST_DONE;
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("stored count above capacity");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (!rst && start && !busy) |=> busy)
    else $error("request taken without going busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (count == CW'(CAPACITY)))
    else $error("full status with room left");

  a_not_found: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_NOT_FOUND) |-> !found)
    else $error("not found status with found set");
`endif

endmodule
